>>> design/lld_pkg.sv
`default_nettype none
package lld_pkg;

	localparam int WORKERS = 16;
	localparam int COUNT_BITS = 16;

	localparam int ADDR_W = (WORKERS > 1) ? $clog2(WORKERS) : 1;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	// widths fixed by the word layout
	localparam int OPCODE_W = 2;
	localparam int WID_W = 4;
	localparam int STATUS_W = 2;
	localparam int CHOSEN_W = 4;
	localparam int LIMIT_W = 16;
	localparam int AWORK_W = 5;
	localparam int TOTAL_W = 16;
	localparam int LIM_W = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd256;
	localparam logic [AWORK_W-1:0] AWORK_RESET = 5'd1;

	localparam logic [OPCODE_W-1:0] OP_NEW = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_CLOSE = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_TICK = 2'd2;

	localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
	localparam logic [STATUS_W-1:0] ST_LIMIT = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [STATUS_W-1:0] ST_BAD_ID = 2'd3;

	localparam logic REG_LIMIT = 1'b0;
	localparam logic REG_WORKERS = 1'b1;

	typedef struct packed {
		logic [LIMIT_W-1:0] limit;
		logic [AWORK_W-1:0] workers;
	} cfg_t;

	typedef struct packed {
		logic latch;
		logic scan_rd;
		logic close_rd;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic [OPCODE_W-1:0] op;
		logic admit;
		logic scan_last;
		logic out_free;
	} stat_t;

endpackage
`default_nettype wire

>>> design/lld_ram.sv
`default_nettype none
module lld_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input wire clk,
	input wire we,
	input wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input wire [WIDTH-1:0] wdata,
	input wire re,
	input wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

>>> design/lld_datapath.sv
`default_nettype none
module lld_datapath (
	input wire clk,
	input wire arst_n,
	input wire lld_pkg::cfg_t cfg,
	input wire lld_pkg::cmd_t cmd,
	output lld_pkg::stat_t stat,
	input wire [lld_pkg::OPCODE_W-1:0] in_op,
	input wire [lld_pkg::WID_W-1:0] in_wid,
	output logic out_valid,
	input wire out_ready,
	output logic [lld_pkg::STATUS_W-1:0] out_status,
	output logic [lld_pkg::CHOSEN_W-1:0] out_chosen,
	output logic out_limit,
	output logic [lld_pkg::TOTAL_W-1:0] out_total
);
	import lld_pkg::*;

	logic [OPCODE_W-1:0] op_q;
	logic [WID_W-1:0] wid_q;
	logic [COUNT_BITS-1:0] total_q;
	logic limit_q;
	logic [WORKERS-1:0] valid_q;
	logic [ADDR_W-1:0] scan_idx_q;
	logic [ADDR_W-1:0] idx_s1;
	logic rd_v_s1;
	logic valid_s1;
	logic [ADDR_W-1:0] best_idx_q;
	logic [COUNT_BITS-1:0] best_load_q;
	logic out_valid_q;

	logic [COUNT_BITS-1:0] rd_data;
	logic [COUNT_BITS-1:0] rd_load;
	logic rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [ADDR_W-1:0] wid_addr;
	logic wid_bad;
	logic [ADDR_W-1:0] last_idx;
	logic [LIM_W-1:0] lim_wide;
	logic [COUNT_BITS-1:0] lim;
	logic [COUNT_BITS-1:0] thr;

	logic we;
	logic [ADDR_W-1:0] waddr;
	logic [COUNT_BITS-1:0] wdata;
	logic [COUNT_BITS-1:0] total_n;
	logic limit_n;
	logic [STATUS_W-1:0] res_status;
	logic [CHOSEN_W-1:0] res_chosen;

	// effective limit never exceeds what a counter holds
	always_comb begin
		lim_wide = LIM_W'(cfg.limit);
		if (lim_wide > LIM_W'(COUNT_MAX)) begin
			lim_wide = LIM_W'(COUNT_MAX);
		end
		lim = COUNT_BITS'(lim_wide);
		thr = lim - (lim >> 3);
	end

	always_comb begin
		if (cfg.workers == '0) begin
			last_idx = '0;
		end else if (int'(cfg.workers) >= WORKERS) begin
			last_idx = ADDR_W'(WORKERS - 1);
		end else begin
			last_idx = ADDR_W'(cfg.workers - AWORK_W'(1));
		end
	end

	assign wid_bad = int'(wid_q) >= WORKERS;
	assign wid_addr = ADDR_W'(wid_q);
	assign rd_en = cmd.scan_rd | cmd.close_rd;
	assign rd_addr = cmd.close_rd ? wid_addr : scan_idx_q;
	// an entry never written reads as zero
	assign rd_load = valid_s1 ? rd_data : '0;

	lld_ram #(
		.WIDTH(COUNT_BITS),
		.DEPTH(WORKERS)
	) u_loads (
		.clk(clk),
		.we(we),
		.waddr(waddr),
		.wdata(wdata),
		.re(rd_en),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	always_comb begin
		res_status = ST_DONE;
		res_chosen = '0;
		total_n = total_q;
		limit_n = limit_q;
		we = 1'b0;
		waddr = best_idx_q;
		wdata = best_load_q + COUNT_BITS'(1);
		case (op_q)
			OP_NEW: begin
				if (limit_q) begin
					res_status = ST_LIMIT;
				end else if (total_q >= lim) begin
					limit_n = 1'b1;
					res_status = ST_LIMIT;
				end else begin
					we = cmd.commit;
					total_n = total_q + COUNT_BITS'(1);
					res_chosen = CHOSEN_W'(best_idx_q);
				end
			end
			OP_CLOSE: begin
				if (wid_bad) begin
					res_status = ST_BAD_ID;
				end else if (rd_load == '0) begin
					res_status = ST_EMPTY;
				end else begin
					we = cmd.commit;
					waddr = wid_addr;
					wdata = rd_load - COUNT_BITS'(1);
					if (total_q != '0) begin
						total_n = total_q - COUNT_BITS'(1);
					end
				end
			end
			OP_TICK: begin
				if (limit_q && total_q <= thr) begin
					limit_n = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			limit_q <= 1'b0;
			valid_q <= '0;
			scan_idx_q <= '0;
			rd_v_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_v_s1 <= cmd.scan_rd;
			if (cmd.latch) begin
				scan_idx_q <= '0;
			end else if (cmd.scan_rd) begin
				scan_idx_q <= scan_idx_q + ADDR_W'(1);
			end
			if (cmd.commit) begin
				total_q <= total_n;
				limit_q <= limit_n;
				if (we) begin
					valid_q[waddr] <= 1'b1;
				end
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q <= in_op;
			wid_q <= in_wid;
		end
		if (rd_en) begin
			valid_s1 <= valid_q[rd_addr];
			idx_s1 <= rd_addr;
		end
		// strict compare keeps the lowest index on a tie
		if (rd_v_s1) begin
			if (idx_s1 == '0 || rd_load < best_load_q) begin
				best_load_q <= rd_load;
				best_idx_q <= idx_s1;
			end
		end
		if (cmd.commit) begin
			out_status <= res_status;
			out_chosen <= res_chosen;
			out_limit <= limit_n;
			out_total <= TOTAL_W'(total_n);
		end
	end

	assign out_valid = out_valid_q;
	assign stat.op = op_q;
	assign stat.admit = !limit_q && (total_q < lim);
	assign stat.scan_last = scan_idx_q == last_idx;
	assign stat.out_free = !out_valid_q || out_ready;

endmodule
`default_nettype wire

>>> design/lld_ctrl.sv
`default_nettype none
module lld_ctrl (
	input wire clk,
	input wire arst_n,
	input wire in_valid,
	output logic in_ready,
	input wire lld_pkg::stat_t stat,
	output lld_pkg::cmd_t cmd
);
	import lld_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_DISPATCH = 6'b000010,
		S_SCAN = 6'b000100,
		S_SCAN_WAIT = 6'b001000,
		S_CLOSE_RD = 6'b010000,
		S_COMMIT = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_n;

	always_comb begin
		state_n = state_q;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_n = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (stat.op == OP_NEW && stat.admit) begin
					state_n = S_SCAN;
				end else if (stat.op == OP_CLOSE) begin
					state_n = S_CLOSE_RD;
				end else begin
					state_n = S_COMMIT;
				end
			end
			S_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (stat.scan_last) begin
					state_n = S_SCAN_WAIT;
				end
			end
			// last compare lands here
			S_SCAN_WAIT: begin
				state_n = S_COMMIT;
			end
			S_CLOSE_RD: begin
				cmd.close_rd = 1'b1;
				state_n = S_COMMIT;
			end
			S_COMMIT: begin
				if (stat.out_free) begin
					cmd.commit = 1'b1;
					state_n = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

endmodule
`default_nettype wire

>>> design/least_loaded_connection_dispatcher.sv
`default_nettype none
// Dispatches new connections to the least-loaded active worker and tracks
// closes, with a connection limit that latches on overload and releases on
// a tick once the total falls to limit - limit/8. One result word per input
// word. With the number of active workers clamped to 1..16, an admitted new
// connection passes through a decode state, one counter read per worker
// from the load memory, a state for the last compare, then the update; a
// close passes through decode, one counter read and the update, and
// everything else through decode and the update. The next word is taken
// the cycle after the current one has moved into the output register; a
// result still held in the output register stalls the update until
// m_tready takes it. Counters come out of reset at zero through per-worker
// valid bits, so no clearing pass is needed. The user must write registers
// over the APB port only while the block is idle; this is not enforced.
module least_loaded_connection_dispatcher (
	input wire clk,
	input wire arst_n,
	input wire s_tvalid,
	output logic s_tready,
	input wire [7:0] s_tdata, // [3:0] worker_id
	input wire [1:0] s_tuser, // [1:0] opcode
	output logic m_tvalid,
	input wire m_tready,
	// [3:0] chosen_worker, [4] limit_active, [20:5] total_count
	output logic [23:0] m_tdata,
	output logic [1:0] m_tuser, // [1:0] status
	input wire psel,
	input wire penable,
	input wire pwrite,
	input wire [2:0] paddr,
	input wire [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import lld_pkg::*;

	cfg_t cfg_q;
	cmd_t cmd;
	stat_t stat;
	logic [STATUS_W-1:0] out_status;
	logic [CHOSEN_W-1:0] out_chosen;
	logic out_limit;
	logic [TOTAL_W-1:0] out_total;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.limit <= LIMIT_RESET;
			cfg_q.workers <= AWORK_RESET;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_LIMIT: cfg_q.limit <= pwdata[LIMIT_W-1:0];
				REG_WORKERS: cfg_q.workers <= pwdata[AWORK_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_LIMIT: prdata = 32'(cfg_q.limit);
			REG_WORKERS: prdata = 32'(cfg_q.workers);
			default: prdata = '0;
		endcase
	end

	lld_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.stat(stat),
		.cmd(cmd)
	);

	lld_datapath u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.cmd(cmd),
		.stat(stat),
		.in_op(s_tuser),
		.in_wid(s_tdata[WID_W-1:0]),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_status(out_status),
		.out_chosen(out_chosen),
		.out_limit(out_limit),
		.out_total(out_total)
	);

	assign m_tuser = out_status;
	assign m_tdata = {3'b000, out_total, out_limit, out_chosen};

endmodule
`default_nettype wire

>>> tb/sv/least_loaded_connection_dispatcher_tb.sv
`default_nettype none
module least_loaded_connection_dispatcher_tb;
	import lld_pkg::*;

	localparam logic [OPCODE_W-1:0] OP_IGNORED = 2'd3;
	localparam int SETTLE_CYCLES = WORKERS + 12;

	typedef struct {
		logic [STATUS_W-1:0] status;
		logic [CHOSEN_W-1:0] chosen;
		logic limit_on;
		logic [TOTAL_W-1:0] total;
	} dispatch_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = '0;
	logic [1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic [1:0] m_tuser;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	// shadow of the block state and registers
	logic [COUNT_BITS-1:0] worker_load [WORKERS];
	logic [COUNT_BITS-1:0] total_held;
	logic limit_latched;
	logic [LIMIT_W-1:0] cfg_limit;
	logic [AWORK_W-1:0] cfg_workers;

	dispatch_result_t pending_results [$];
	int mismatch_count = 0;
	bit quiet = 1'b0;
	int hold_left = 0;

	always #5 clk = ~clk;

	least_loaded_connection_dispatcher DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	task automatic report_mismatch(input string msg);
		if (mismatch_count < 50) $display("%0t: %s", $time, msg);
		mismatch_count++;
	endtask

	function automatic int pick_gap();
		int r;
		if (quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic dispatch_result_t dispatch_predict(input logic [OPCODE_W-1:0] op,
			input logic [WID_W-1:0] wid);
		dispatch_result_t r;
		logic [COUNT_BITS-1:0] lim;
		int span;
		int best;
		r.status = ST_DONE;
		r.chosen = '0;
		lim = (cfg_limit < COUNT_MAX) ? COUNT_BITS'(cfg_limit) : COUNT_MAX;
		case (op)
			OP_NEW: begin
				if (limit_latched) begin
					r.status = ST_LIMIT;
				end else if (total_held >= lim) begin
					limit_latched = 1'b1;
					r.status = ST_LIMIT;
				end else begin
					span = int'(cfg_workers);
					if (span < 1) span = 1;
					if (span > WORKERS) span = WORKERS;
					best = 0;
					for (int i = 1; i < span; i++)
						if (worker_load[i] < worker_load[best]) best = i;
					worker_load[best] = worker_load[best] + COUNT_BITS'(1);
					total_held = total_held + COUNT_BITS'(1);
					r.chosen = best[CHOSEN_W-1:0];
				end
			end
			OP_CLOSE: begin
				if (int'(wid) >= WORKERS) begin
					r.status = ST_BAD_ID;
				end else if (worker_load[wid] == 0) begin
					r.status = ST_EMPTY;
				end else begin
					worker_load[wid] = worker_load[wid] - COUNT_BITS'(1);
					if (total_held > 0) total_held = total_held - COUNT_BITS'(1);
				end
			end
			OP_TICK: begin
				// release once the total is at or below the hysteresis floor
				if (limit_latched && total_held <= lim - lim / 8) limit_latched = 1'b0;
			end
			default: ;
		endcase
		r.limit_on = limit_latched;
		r.total = total_held;
		return r;
	endfunction

	task automatic send_word(input logic [OPCODE_W-1:0] op, input logic [WID_W-1:0] wid);
		int gap;
		logic [3:0] pad;
		gap = pick_gap();
		pad = 4'($urandom);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {pad, wid};
		do @(posedge clk); while (s_tready !== 1'b1);
		pending_results.push_back(dispatch_predict(op, wid));
	endtask

	// stop sending and let the block drain completely
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [31:0] value);
		logic [31:0] word;
		word = $urandom;
		if (idx == REG_LIMIT) word[LIMIT_W-1:0] = value[LIMIT_W-1:0];
		else word[AWORK_W-1:0] = value[AWORK_W-1:0];
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= word;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel <= 1'b0;
		penable <= 1'b0;
		if (idx == REG_LIMIT) cfg_limit = value[LIMIT_W-1:0];
		else cfg_workers = value[AWORK_W-1:0];
	endtask

	// result side: compare and pick the next stall
	always @(posedge clk) begin
		dispatch_result_t want;
		int g;
		if (m_tvalid === 1'b1 && m_tready === 1'b1) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result word with nothing expected: %h/%h",
					m_tuser, m_tdata));
			end else begin
				want = pending_results.pop_front();
				if (m_tuser !== want.status)
					report_mismatch($sformatf("status: expected %0d got %0d",
						want.status, m_tuser));
				if (m_tdata[3:0] !== want.chosen)
					report_mismatch($sformatf("chosen_worker: expected %0d got %0d",
						want.chosen, m_tdata[3:0]));
				if (m_tdata[4] !== want.limit_on)
					report_mismatch($sformatf("limit_active: expected %0d got %0d",
						want.limit_on, m_tdata[4]));
				if (m_tdata[20:5] !== want.total)
					report_mismatch($sformatf("total_count: expected %0d got %0d",
						want.total, m_tdata[20:5]));
			end
		end
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			g = pick_gap();
			if (g == 0) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b0;
				hold_left <= g - 1;
			end
		end
	end

	task automatic test_reset_defaults();
		// one worker and a limit of 256 straight out of reset
		send_word(OP_NEW, 4'($urandom));
		send_word(OP_CLOSE, 4'd0);
		send_word(OP_CLOSE, 4'd0);
		send_word(OP_CLOSE, 4'd15);
		send_word(OP_TICK, 4'($urandom));
		send_word(OP_IGNORED, 4'($urandom));
	endtask

	task automatic test_limit_hysteresis();
		settle();
		write_reg(REG_LIMIT, 32'd8);
		write_reg(REG_WORKERS, 32'd16);
		// eight admitted, ninth latches the limit, tenth refused while latched
		repeat (10) send_word(OP_NEW, 4'($urandom));
		send_word(OP_TICK, 4'($urandom));
		send_word(OP_CLOSE, 4'd2);
		send_word(OP_TICK, 4'($urandom));
		send_word(OP_NEW, 4'($urandom));
	endtask

	task automatic test_limit_extremes();
		settle();
		write_reg(REG_LIMIT, 32'd0);
		send_word(OP_NEW, 4'($urandom));
		send_word(OP_TICK, 4'($urandom));
		settle();
		write_reg(REG_LIMIT, 32'd65535);
		send_word(OP_TICK, 4'($urandom));
	endtask

	task automatic test_worker_span();
		settle();
		write_reg(REG_WORKERS, 32'd31);
		send_word(OP_NEW, 4'($urandom));
		settle();
		write_reg(REG_WORKERS, 32'd0);
		send_word(OP_NEW, 4'($urandom));
		settle();
		write_reg(REG_WORKERS, 32'd17);
		send_word(OP_NEW, 4'($urandom));
		send_word(OP_CLOSE, 4'd15);
	endtask

	task automatic test_random_traffic();
		int r;
		int span;
		logic [WID_W-1:0] wid;
		logic [OPCODE_W-1:0] op;
		for (int phase = 0; phase < 10; phase++) begin
			settle();
			r = $urandom_range(0, 9);
			if (r < 6) write_reg(REG_LIMIT, $urandom_range(0, 40));
			else if (r < 9) write_reg(REG_LIMIT, $urandom_range(41, 300));
			else if ($urandom_range(0, 1)) write_reg(REG_LIMIT, 32'd65535);
			else write_reg(REG_LIMIT, $urandom_range(0, 65535));
			write_reg(REG_WORKERS, $urandom_range(0, 31));
			quiet = (phase % 4 == 3);
			span = int'(cfg_workers);
			if (span < 1) span = 1;
			if (span > WORKERS) span = WORKERS;
			for (int n = 0; n < 100; n++) begin
				if ($urandom_range(0, 199) == 0) settle();
				wid = WID_W'($urandom);
				r = $urandom_range(0, 99);
				if (r < 48) begin
					op = OP_NEW;
				end else if (r < 80) begin
					op = OP_CLOSE;
					// mostly close a worker that actually holds something
					if ($urandom_range(0, 9) < 7) begin
						wid = WID_W'($urandom_range(0, span - 1));
						for (int k = 0; k < WORKERS && worker_load[wid] == 0; k++)
							wid = wid + 1'b1;
					end
				end else if (r < 94) begin
					op = OP_TICK;
				end else begin
					op = OP_IGNORED;
				end
				send_word(op, wid);
			end
			quiet = 1'b0;
		end
	endtask

	initial begin
		for (int i = 0; i < WORKERS; i++) worker_load[i] = '0;
		total_held = '0;
		limit_latched = 1'b0;
		cfg_limit = LIMIT_RESET;
		cfg_workers = AWORK_RESET;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_limit_hysteresis();
		test_limit_extremes();
		test_worker_span();
		test_random_traffic();
		settle();
		if (mismatch_count == 0) begin
			$display("least_loaded_connection_dispatcher verification clean");
		end else begin
			$display("least_loaded_connection_dispatcher verification failed");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("least_loaded_connection_dispatcher verification failed");
		$finish;
	end

endmodule
`default_nettype wire
